// ===== sv/adcu_pkg.sv =====
// ----------------------------------------------------------------------------
// adcu_pkg
// Shared types and constants for the advection-diffusion cell update pipeline.
// ----------------------------------------------------------------------------
package adcu_pkg;

	// Coefficient register width and internal accumulator width
	localparam int COEF_W    = 32;
	localparam int ACC_W     = 64;
	localparam int CFG_IDX_W = 2;

	// Latency of one rounding multiplier, in register stages
	localparam int MUL_LAT = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ADVECT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd2;

	// Clamped product or sum with its overflow flag
	typedef struct packed {
		logic                    sat;
		logic signed [ACC_W-1:0] val;
	} prod_t;

endpackage

// ===== sv/adcu_mulsh.sv =====
// ----------------------------------------------------------------------------
// adcu_mulsh
// Pipelined signed multiply, round half away from zero, shift right and
// clamp to the signed accumulator range. Operands split into halves so each
// partial product stays near 32x32. Four register stages.
// ----------------------------------------------------------------------------
module adcu_mulsh #(
	parameter int A_W   = 33,
	parameter int B_W   = 32,
	parameter int SHIFT = 28
) (
	input  logic                  clk,
	input  logic signed [A_W-1:0] a,
	input  logic signed [B_W-1:0] b,
	output adcu_pkg::prod_t       res
);
	import adcu_pkg::*;

	localparam int AL = (A_W + 1) / 2;
	localparam int AH = A_W - AL;
	localparam int BL = (B_W + 1) / 2;
	localparam int BH = B_W - BL;
	localparam int PW = A_W + B_W;
	localparam int MW = PW + 1;
	localparam int EW = ((PW > ACC_W) ? PW : ACC_W) + 2;

	localparam logic signed [EW-1:0] HALF    = {{(EW-1){1'b0}}, 1'b1} << (SHIFT - 1);
	localparam logic signed [EW-1:0] HALF_M1 = HALF - {{(EW-1){1'b0}}, 1'b1};

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic signed [AH-1:0]      a_hi;
	logic        [AL-1:0]      a_lo;
	logic signed [BH-1:0]      b_hi;
	logic        [BL-1:0]      b_lo;

	logic signed [AH+BH-1:0]   pp_hh_s1;
	logic signed [AH+BL:0]     pp_hl_s1;
	logic signed [AL+BH:0]     pp_lh_s1;
	logic        [AL+BL-1:0]   pp_ll_s1;

	logic signed [PW-1:0]      outer_s2;
	logic signed [MW-1:0]      mid_s2;

	logic signed [EW-1:0]      prod_s3;

	logic signed [EW-1:0]      rnd_sum;
	logic signed [EW-1:0]      rnd;
	logic [EW-ACC_W:0]         rnd_top;
	logic                      ovf;
	prod_t                     res_s4;

	// Split operands into signed high and unsigned low halves
	assign a_hi = a[A_W-1:AL];
	assign a_lo = a[AL-1:0];
	assign b_hi = b[B_W-1:BL];
	assign b_lo = b[BL-1:0];

	// Stage 1: partial products
	always_ff @(posedge clk) begin
		pp_hh_s1 <= a_hi * b_hi;
		pp_hl_s1 <= a_hi * $signed({1'b0, b_lo});
		pp_lh_s1 <= $signed({1'b0, a_lo}) * b_hi;
		pp_ll_s1 <= a_lo * b_lo;
	end

	// Stage 2: merge cross terms, place outer terms side by side
	always_ff @(posedge clk) begin
		outer_s2 <= {pp_hh_s1, pp_ll_s1};
		mid_s2   <= (MW'(pp_hl_s1) <<< AL) + (MW'(pp_lh_s1) <<< BL);
	end

	// Stage 3: full product
	always_ff @(posedge clk) begin
		prod_s3 <= EW'(outer_s2) + EW'(mid_s2);
	end

	// Round half away from zero, then clamp to the accumulator range
	always_comb begin
		rnd_sum = prod_s3 + (prod_s3[EW-1] ? HALF_M1 : HALF);
		rnd     = rnd_sum >>> SHIFT;
		rnd_top = rnd[EW-1:ACC_W-1];
		ovf     = !((&rnd_top) || !(|rnd_top));
	end

	// Stage 4: clamped result
	always_ff @(posedge clk) begin
		res_s4.sat <= ovf;
		if (ovf) begin
			res_s4.val <= rnd[EW-1] ? ACC_MIN : ACC_MAX;
		end else begin
			res_s4.val <= rnd[ACC_W-1:0];
		end
	end

	assign res = res_s4;

endmodule

// ===== sv/advection_diffusion_cell_update_top.sv =====
// ----------------------------------------------------------------------------
// advection_diffusion_cell_update_top
// Crank-Nicolson advection-diffusion update of one grid cell per request.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   request  | start / busy        | old_*, est_*, vel_x, vel_y, cell_active
//   result   | done (one cycle)    | new_value, saturated
//   config   | cfg_write           | cfg_index, cfg_data
//
// A request is taken every cycle; busy stays low. Each result appears on done
// after three chained 4-stage multipliers (velocity scaling, advection term,
// centre scaling) plus five add stages and a final select stage.
// Reset clears the stage valid bits and loads the coefficient defaults.
// The pipeline never stalls: results leave in request order, one per cycle.
// ----------------------------------------------------------------------------
module advection_diffusion_cell_update_top #(
	parameter int VALUE_BITS      = 32,
	parameter int VALUE_FRAC_BITS = 16,
	parameter int COEF_FRAC_BITS  = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [VALUE_BITS-1:0]         old_centre,
	input  logic signed [VALUE_BITS-1:0]         old_east,
	input  logic signed [VALUE_BITS-1:0]         old_west,
	input  logic signed [VALUE_BITS-1:0]         old_north,
	input  logic signed [VALUE_BITS-1:0]         old_south,
	input  logic signed [VALUE_BITS-1:0]         est_east,
	input  logic signed [VALUE_BITS-1:0]         est_west,
	input  logic signed [VALUE_BITS-1:0]         est_north,
	input  logic signed [VALUE_BITS-1:0]         est_south,
	input  logic signed [VALUE_BITS-1:0]         vel_x,
	input  logic signed [VALUE_BITS-1:0]         vel_y,
	input  logic                                 cell_active,
	output logic                                 done,
	output logic signed [VALUE_BITS-1:0]         new_value,
	output logic                                 saturated,
	input  logic                                 cfg_write,
	input  logic [adcu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adcu_pkg::COEF_W-1:0]          cfg_data
);
	import adcu_pkg::*;

	localparam int VB         = VALUE_BITS;
	localparam int DW         = VB + 2;
	localparam int LW         = VB + 4;
	localparam int CW         = COEF_W + 1;
	localparam int PIPE_DEPTH = 6 + 3 * MUL_LAT;

	localparam logic [COEF_W-1:0] SCALE_RST = COEF_W'(64'd1 << COEF_FRAC_BITS);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [VB-1:0]    VAL_MAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0]    VAL_MIN = {1'b1, {(VB-1){1'b0}}};

	typedef struct packed {
		logic                 act;
		logic signed [VB-1:0] uc;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} side_a_t;

	typedef struct packed {
		logic                    act;
		logic                    sat;
		logic signed [VB-1:0]    uc;
		logic signed [ACC_W-1:0] td;
	} side_b_t;

	typedef struct packed {
		logic                 act;
		logic                 sat;
		logic signed [VB-1:0] uc;
	} side_c_t;

	// Saturating 64-bit add or subtract
	function automatic prod_t sat_acc(input logic signed [ACC_W-1:0] x,
		input logic signed [ACC_W-1:0] y, input logic sub);
		logic signed [ACC_W:0] ye;
		logic signed [ACC_W:0] w;
		prod_t                 o;
		ye = {y[ACC_W-1], y};
		w  = {x[ACC_W-1], x} + (sub ? -ye : ye);
		o.sat = (w[ACC_W] != w[ACC_W-1]);
		if (o.sat) begin
			o.val = w[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			o.val = w[ACC_W-1:0];
		end
		return o;
	endfunction

	logic [COEF_W-1:0]         advect_q;
	logic [COEF_W-1:0]         diffuse_q;
	logic [COEF_W-1:0]         scale_q;

	logic                      accept;
	logic [PIPE_DEPTH:1]       valid_s;

	logic                      act_s1;
	logic signed [VB-1:0]      uc_s1;
	logic signed [DW-1:0]      dx_s1;
	logic signed [DW-1:0]      dy_s1;
	logic signed [DW-1:0]      sum_old_s1;
	logic signed [DW-1:0]      sum_est_s1;
	logic signed [VB-1:0]      vx_s1;
	logic signed [VB-1:0]      vy_s1;

	side_a_t                   side_s2;
	logic signed [LW-1:0]      lap_s2;
	logic signed [VB-1:0]      vx_s2;
	logic signed [VB-1:0]      vy_s2;

	side_a_t                   grp1_side_s [MUL_LAT];
	side_a_t                   side_s6;
	prod_t                     ax_s6;
	prod_t                     ay_s6;
	prod_t                     td_s6;

	side_b_t                   grp2_side_s [MUL_LAT];
	side_b_t                   side_s10;
	prod_t                     tx_s10;
	prod_t                     ty_s10;

	prod_t                     sub_tx;
	prod_t                     sub_ty;
	prod_t                     add_td;

	logic                      act_s11;
	logic                      sat_s11;
	logic signed [VB-1:0]      uc_s11;
	logic signed [ACC_W-1:0]   acc_s11;
	logic signed [ACC_W-1:0]   ty_s11;
	logic signed [ACC_W-1:0]   td_s11;

	logic                      act_s12;
	logic                      sat_s12;
	logic signed [VB-1:0]      uc_s12;
	logic signed [ACC_W-1:0]   acc_s12;
	logic signed [ACC_W-1:0]   td_s12;

	logic                      act_s13;
	logic                      sat_s13;
	logic signed [VB-1:0]      uc_s13;
	logic signed [ACC_W-1:0]   acc_s13;

	side_c_t                   grp3_side_s [MUL_LAT];
	side_c_t                   side_s17;
	prod_t                     r_s17;

	logic [ACC_W-VB:0]         r_top;
	logic                      r_ovf;
	logic signed [VB-1:0]      r_clamped;

	logic signed [VB-1:0]      value_s18;
	logic                      sat_s18;

	// Pipeline takes a request every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			advect_q  <= '0;
			diffuse_q <= '0;
			scale_q   <= SCALE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ADVECT:  advect_q  <= cfg_data;
				REG_DIFFUSE: diffuse_q <= cfg_data;
				REG_SCALE:   scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[PIPE_DEPTH-1:1], accept};
		end
	end

	// Stage 1: differences and neighbor sums
	always_ff @(posedge clk) begin
		act_s1     <= cell_active;
		uc_s1      <= old_centre;
		vx_s1      <= vel_x;
		vy_s1      <= vel_y;
		dx_s1      <= (DW'(old_east) - DW'(old_west)) + (DW'(est_east) - DW'(est_west));
		dy_s1      <= (DW'(old_north) - DW'(old_south)) + (DW'(est_north) - DW'(est_south));
		sum_old_s1 <= (DW'(old_east) + DW'(old_west)) + (DW'(old_north) + DW'(old_south));
		sum_est_s1 <= (DW'(est_east) + DW'(est_west)) + (DW'(est_north) + DW'(est_south));
	end

	// Stage 2: Laplacian sum
	always_ff @(posedge clk) begin
		side_s2.act <= act_s1;
		side_s2.uc  <= uc_s1;
		side_s2.dx  <= dx_s1;
		side_s2.dy  <= dy_s1;
		vx_s2       <= vx_s1;
		vy_s2       <= vy_s1;
		lap_s2      <= (LW'(sum_old_s1) + LW'(sum_est_s1)) - (LW'(uc_s1) <<< 2);
	end

	// Scale velocities and the Laplacian by their coefficients
	adcu_mulsh #(.A_W(CW), .B_W(VB), .SHIFT(COEF_FRAC_BITS)) u_mul_ax (
		.clk (clk),
		.a   ($signed({1'b0, advect_q})),
		.b   (vx_s2),
		.res (ax_s6)
	);

	adcu_mulsh #(.A_W(CW), .B_W(VB), .SHIFT(COEF_FRAC_BITS)) u_mul_ay (
		.clk (clk),
		.a   ($signed({1'b0, advect_q})),
		.b   (vy_s2),
		.res (ay_s6)
	);

	adcu_mulsh #(.A_W(CW), .B_W(LW), .SHIFT(COEF_FRAC_BITS)) u_mul_td (
		.clk (clk),
		.a   ($signed({1'b0, diffuse_q})),
		.b   (lap_s2),
		.res (td_s6)
	);

	// Hold side data across the first multiplier group
	always_ff @(posedge clk) begin
		grp1_side_s[0] <= side_s2;
		for (int i = 1; i < MUL_LAT; i++) begin
			grp1_side_s[i] <= grp1_side_s[i-1];
		end
	end

	assign side_s6 = grp1_side_s[MUL_LAT-1];

	// Advection terms
	adcu_mulsh #(.A_W(ACC_W), .B_W(DW), .SHIFT(VALUE_FRAC_BITS)) u_mul_tx (
		.clk (clk),
		.a   (ax_s6.val),
		.b   (side_s6.dx),
		.res (tx_s10)
	);

	adcu_mulsh #(.A_W(ACC_W), .B_W(DW), .SHIFT(VALUE_FRAC_BITS)) u_mul_ty (
		.clk (clk),
		.a   (ay_s6.val),
		.b   (side_s6.dy),
		.res (ty_s10)
	);

	// Hold side data across the second multiplier group
	always_ff @(posedge clk) begin
		grp2_side_s[0].act <= side_s6.act;
		grp2_side_s[0].sat <= ax_s6.sat | ay_s6.sat | td_s6.sat;
		grp2_side_s[0].uc  <= side_s6.uc;
		grp2_side_s[0].td  <= td_s6.val;
		for (int i = 1; i < MUL_LAT; i++) begin
			grp2_side_s[i] <= grp2_side_s[i-1];
		end
	end

	assign side_s10 = grp2_side_s[MUL_LAT-1];

	// Saturating sum, one term per stage in order
	assign sub_tx = sat_acc(ACC_W'(side_s10.uc), tx_s10.val, 1'b1);
	assign sub_ty = sat_acc(acc_s11, ty_s11, 1'b1);
	assign add_td = sat_acc(acc_s12, td_s12, 1'b0);

	always_ff @(posedge clk) begin
		act_s11 <= side_s10.act;
		uc_s11  <= side_s10.uc;
		sat_s11 <= side_s10.sat | tx_s10.sat | ty_s10.sat | sub_tx.sat;
		acc_s11 <= sub_tx.val;
		ty_s11  <= ty_s10.val;
		td_s11  <= side_s10.td;

		act_s12 <= act_s11;
		uc_s12  <= uc_s11;
		sat_s12 <= sat_s11 | sub_ty.sat;
		acc_s12 <= sub_ty.val;
		td_s12  <= td_s11;

		act_s13 <= act_s12;
		uc_s13  <= uc_s12;
		sat_s13 <= sat_s12 | add_td.sat;
		acc_s13 <= add_td.val;
	end

	// Centre scaling
	adcu_mulsh #(.A_W(CW), .B_W(ACC_W), .SHIFT(COEF_FRAC_BITS)) u_mul_r (
		.clk (clk),
		.a   ($signed({1'b0, scale_q})),
		.b   (acc_s13),
		.res (r_s17)
	);

	// Hold side data across the last multiplier
	always_ff @(posedge clk) begin
		grp3_side_s[0].act <= act_s13;
		grp3_side_s[0].sat <= sat_s13;
		grp3_side_s[0].uc  <= uc_s13;
		for (int i = 1; i < MUL_LAT; i++) begin
			grp3_side_s[i] <= grp3_side_s[i-1];
		end
	end

	assign side_s17 = grp3_side_s[MUL_LAT-1];

	// Clamp to the value range
	always_comb begin
		r_top = r_s17.val[ACC_W-1:VB-1];
		r_ovf = !((&r_top) || !(|r_top));
		if (r_ovf) begin
			r_clamped = r_s17.val[ACC_W-1] ? VAL_MIN : VAL_MAX;
		end else begin
			r_clamped = r_s17.val[VB-1:0];
		end
	end

	// Stage 18: select pass-through for inactive cells, drop flag when idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_s18 <= 1'b0;
		end else begin
			sat_s18 <= valid_s[PIPE_DEPTH-1] && side_s17.act
				&& (side_s17.sat || r_s17.sat || r_ovf);
		end
	end

	always_ff @(posedge clk) begin
		value_s18 <= side_s17.act ? r_clamped : side_s17.uc;
	end

	assign done      = valid_s[PIPE_DEPTH];
	assign new_value = value_s18;
	assign saturated = sat_s18;

	// Every result traces back to a request a fixed latency earlier
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("result without matching request");

	// The flag only rides on a result
	a_sat_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !saturated)
		else $error("saturated raised without a result");

	// Inactive cells pass the old centre through unflagged
	a_inactive_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(cell_active, PIPE_DEPTH))
			|-> (new_value == $past(old_centre, PIPE_DEPTH)) && !saturated)
		else $error("inactive cell not passed through");

endmodule

// ===== dv/adcu_cell_checker.sv =====
// ----------------------------------------------------------------------------
// adcu_cell_checker
// Watches the request, result and register channels of the cell update block.
// Keeps its own copy of the coefficients, computes the expected new value and
// clamp flag for every accepted request, and compares results in order.
// ----------------------------------------------------------------------------
module adcu_cell_checker #(
	parameter int VALUE_BITS      = 32,
	parameter int VALUE_FRAC_BITS = 16,
	parameter int COEF_FRAC_BITS  = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic signed [VALUE_BITS-1:0]         old_centre,
	input  logic signed [VALUE_BITS-1:0]         old_east,
	input  logic signed [VALUE_BITS-1:0]         old_west,
	input  logic signed [VALUE_BITS-1:0]         old_north,
	input  logic signed [VALUE_BITS-1:0]         old_south,
	input  logic signed [VALUE_BITS-1:0]         est_east,
	input  logic signed [VALUE_BITS-1:0]         est_west,
	input  logic signed [VALUE_BITS-1:0]         est_north,
	input  logic signed [VALUE_BITS-1:0]         est_south,
	input  logic signed [VALUE_BITS-1:0]         vel_x,
	input  logic signed [VALUE_BITS-1:0]         vel_y,
	input  logic                                 cell_active,
	input  logic                                 done,
	input  logic signed [VALUE_BITS-1:0]         new_value,
	input  logic                                 saturated,
	input  logic                                 cfg_write,
	input  logic [adcu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adcu_pkg::COEF_W-1:0]          cfg_data,
	output int                                   pending_cells,
	output int                                   mismatch_count
);
	import adcu_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [COEF_W-1:0]       SCALE_ONE = COEF_W'(1) << COEF_FRAC_BITS;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         sat;
	} cell_result_t;

	// Local copy of the coefficient registers
	logic [COEF_W-1:0] advect_coef  = '0;
	logic [COEF_W-1:0] diffuse_coef = '0;
	logic [COEF_W-1:0] centre_scale = SCALE_ONE;

	cell_result_t expected_cells[$];
	cell_result_t oldest;

	// Exact product, rounded to nearest with ties away from zero, clamped to 64 bits
	function automatic prod_t round_mul(longint x, longint y, int sh);
		logic [ACC_W-1:0]   ux, uy;
		logic [2*ACC_W-1:0] mag, lim;
		logic               neg;
		prod_t              res;
		neg = (x < 0) != (y < 0);
		ux  = (x < 0) ? 64'd0 - $unsigned(x) : $unsigned(x);
		uy  = (y < 0) ? 64'd0 - $unsigned(y) : $unsigned(y);
		mag = ({64'd0, ux} * {64'd0, uy} + (128'd1 << (sh - 1))) >> sh;
		lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
		res.sat = mag > lim;
		if (res.sat)
			mag = lim;
		res.val = neg ? (64'd0 - mag[ACC_W-1:0]) : mag[ACC_W-1:0];
		return res;
	endfunction

	// Add or subtract with the result clamped to 64 bits
	function automatic prod_t add_clamp(longint a, longint b, logic sub);
		logic signed [ACC_W:0] w;
		prod_t                 res;
		if (sub)
			w = $signed({a[ACC_W-1], a}) - $signed({b[ACC_W-1], b});
		else
			w = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
		res.sat = w[ACC_W] != w[ACC_W-1];
		if (res.sat)
			res.val = w[ACC_W] ? ACC_MIN : ACC_MAX;
		else
			res.val = w[ACC_W-1:0];
		return res;
	endfunction

	// Compute the updated cell value and clamp flag for one request
	function automatic cell_result_t next_cell_value(
		logic signed [VALUE_BITS-1:0] c,
		logic signed [VALUE_BITS-1:0] e0, w0, n0, s0,
		logic signed [VALUE_BITS-1:0] e1, w1, n1, s1,
		logic signed [VALUE_BITS-1:0] vx, vy,
		logic                         act
	);
		longint       dx, dy, lap, rv, vmax, vmin;
		prod_t        ax, ay, tx, ty, td, sa, sb, sc, r;
		cell_result_t res;
		if (!act) begin
			res.value = c;
			res.sat   = 1'b0;
			return res;
		end
		dx  = (longint'(e0) - longint'(w0)) + (longint'(e1) - longint'(w1));
		dy  = (longint'(n0) - longint'(s0)) + (longint'(n1) - longint'(s1));
		lap = (longint'(e0) + longint'(w0) + longint'(n0) + longint'(s0))
			- 4 * longint'(c)
			+ (longint'(e1) + longint'(w1) + longint'(n1) + longint'(s1));
		ax = round_mul(longint'(advect_coef), longint'(vx), COEF_FRAC_BITS);
		ay = round_mul(longint'(advect_coef), longint'(vy), COEF_FRAC_BITS);
		tx = round_mul(ax.val, dx, VALUE_FRAC_BITS);
		ty = round_mul(ay.val, dy, VALUE_FRAC_BITS);
		td = round_mul(longint'(diffuse_coef), lap, COEF_FRAC_BITS);
		sa = add_clamp(longint'(c), tx.val, 1'b1);
		sb = add_clamp(sa.val, ty.val, 1'b1);
		sc = add_clamp(sb.val, td.val, 1'b0);
		r  = round_mul(longint'(centre_scale), sc.val, COEF_FRAC_BITS);
		res.sat = ax.sat | ay.sat | tx.sat | ty.sat | td.sat
			| sa.sat | sb.sat | sc.sat | r.sat;
		// Clamp to the value range
		vmax = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
		vmin = -vmax - 1;
		rv   = r.val;
		if (rv > vmax) begin
			rv      = vmax;
			res.sat = 1'b1;
		end
		if (rv < vmin) begin
			rv      = vmin;
			res.sat = 1'b1;
		end
		res.value = rv[VALUE_BITS-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			advect_coef    = '0;
			diffuse_coef   = '0;
			centre_scale   = SCALE_ONE;
			mismatch_count = 0;
			expected_cells.delete();
			pending_cells <= 0;
		end else begin
			// Predict each accepted request with the current coefficients
			if (start && !busy)
				expected_cells.push_back(next_cell_value(old_centre,
					old_east, old_west, old_north, old_south,
					est_east, est_west, est_north, est_south,
					vel_x, vel_y, cell_active));
			// Compare each result with the oldest prediction
			if (done) begin
				if (expected_cells.size() == 0) begin
					report_mismatch($sformatf("result with no request pending, new_value=%0d",
						new_value));
				end else begin
					oldest = expected_cells.pop_front();
					if (new_value !== oldest.value)
						report_mismatch($sformatf("new_value %0d, expected %0d",
							new_value, oldest.value));
					if (saturated !== oldest.sat)
						report_mismatch($sformatf("saturated %b, expected %b",
							saturated, oldest.sat));
				end
			end
			// Track register writes; unknown indexes are dropped
			if (cfg_write) begin
				case (cfg_index)
					REG_ADVECT:  advect_coef  = cfg_data;
					REG_DIFFUSE: diffuse_coef = cfg_data;
					REG_SCALE:   centre_scale = cfg_data;
					default: ;
				endcase
			end
			pending_cells <= expected_cells.size();
		end
	end

endmodule

// ===== dv/tb_advection_diffusion_cell_update_top.sv =====
// ----------------------------------------------------------------------------
// tb_advection_diffusion_cell_update_top
// Drives cell update requests and coefficient writes into the block.
// A directed set covers field extremes, inactive cells, strong advection and
// diffusion and clamping; random cells then run under several coefficient
// sets with random request gaps. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_advection_diffusion_cell_update_top;
	import adcu_pkg::*;

	localparam int VALUE_BITS      = 32;
	localparam int VALUE_FRAC_BITS = 16;
	localparam int COEF_FRAC_BITS  = 28;

	localparam int RANDOM_ITEMS  = 900;
	localparam int RANDOM_PHASES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 40;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_ONE = 32'sh0001_0000;

	// Typical coefficients: A = 0.05, B = 0.1, C = 1/1.4
	localparam logic [COEF_W-1:0] ADVECT_TYPICAL  = 32'd13421773;
	localparam logic [COEF_W-1:0] DIFFUSE_TYPICAL = 32'd26843546;
	localparam logic [COEF_W-1:0] SCALE_TYPICAL   = 32'd191739611;
	localparam logic [COEF_W-1:0] COEF_MAX        = '1;

	// Coefficient set styles for the random phases
	typedef enum int {
		COEFS_PHYSICAL,
		COEFS_EXTREME,
		COEFS_RAW
	} coef_style_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] centre;
		logic signed [VALUE_BITS-1:0] o_east, o_west, o_north, o_south;
		logic signed [VALUE_BITS-1:0] e_east, e_west, e_north, e_south;
		logic signed [VALUE_BITS-1:0] vx, vy;
		logic                         active;
	} cell_req_t;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         start       = 1'b0;
	logic                         busy;
	logic signed [VALUE_BITS-1:0] old_centre  = '0;
	logic signed [VALUE_BITS-1:0] old_east    = '0;
	logic signed [VALUE_BITS-1:0] old_west    = '0;
	logic signed [VALUE_BITS-1:0] old_north   = '0;
	logic signed [VALUE_BITS-1:0] old_south   = '0;
	logic signed [VALUE_BITS-1:0] est_east    = '0;
	logic signed [VALUE_BITS-1:0] est_west    = '0;
	logic signed [VALUE_BITS-1:0] est_north   = '0;
	logic signed [VALUE_BITS-1:0] est_south   = '0;
	logic signed [VALUE_BITS-1:0] vel_x       = '0;
	logic signed [VALUE_BITS-1:0] vel_y       = '0;
	logic                         cell_active = 1'b0;
	logic                         done;
	logic signed [VALUE_BITS-1:0] new_value;
	logic                         saturated;
	logic                         cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index   = '0;
	logic [COEF_W-1:0]            cfg_data    = '0;
	int                           pending_cells;
	int                           mismatch_count;
	int                           cycle_count = 0;

	always #5 clk = ~clk;

	advection_diffusion_cell_update_top #(
		.VALUE_BITS      (VALUE_BITS),
		.VALUE_FRAC_BITS (VALUE_FRAC_BITS),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS)
	) u_dut (.*);

	adcu_cell_checker #(
		.VALUE_BITS      (VALUE_BITS),
		.VALUE_FRAC_BITS (VALUE_FRAC_BITS),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS)
	) u_checker (.*);

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic cell_req_t make_cell(
		logic signed [VALUE_BITS-1:0] c,
		logic signed [VALUE_BITS-1:0] e0, w0, n0, s0,
		logic signed [VALUE_BITS-1:0] e1, w1, n1, s1,
		logic signed [VALUE_BITS-1:0] vx, vy,
		logic                         act
	);
		return '{c, e0, w0, n0, s0, e1, w1, n1, s1, vx, vy, act};
	endfunction

	function automatic cell_req_t fill_cell(logic signed [VALUE_BITS-1:0] v, logic act);
		return make_cell(v, v, v, v, v, v, v, v, v, v, v, act);
	endfunction

	// Mix of extremes, values near zero and full-range values
	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		logic [31:0] r;
		case ($urandom_range(0, 9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3, 4: begin
				r = $urandom_range(0, 32'h0008_0000);
				return r - 32'h0004_0000;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic cell_req_t random_cell();
		return make_cell(pick_value(), pick_value(), pick_value(), pick_value(),
			pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
			pick_value(), pick_value(), $urandom_range(0, 9) != 0);
	endfunction

	// Mostly back to back, some short gaps, a few long ones; none when steady
	function automatic int unsigned gap_len(bit steady);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request and hold it until accepted
	task automatic send_cell(input cell_req_t c);
		start       <= 1'b1;
		old_centre  <= c.centre;
		old_east    <= c.o_east;
		old_west    <= c.o_west;
		old_north   <= c.o_north;
		old_south   <= c.o_south;
		est_east    <= c.e_east;
		est_west    <= c.e_west;
		est_north   <= c.e_north;
		est_south   <= c.e_south;
		vel_x       <= c.vx;
		vel_y       <= c.vy;
		cell_active <= c.active;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_requests(input int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Wait until every outstanding request has produced its result
	task automatic drain_cells();
		start <= 1'b0;
		do @(posedge clk); while (pending_cells != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic load_coefs(
		input logic [COEF_W-1:0] a,
		input logic [COEF_W-1:0] b,
		input logic [COEF_W-1:0] c,
		input bit                stray
	);
		write_reg(REG_ADVECT, a);
		write_reg(REG_DIFFUSE, b);
		write_reg(REG_SCALE, c);
		if (stray)
			write_reg(REG_SPARE, $urandom);
		cfg_write <= 1'b0;
	endtask

	task automatic load_random_coefs(input coef_style_t style, input bit stray);
		logic [COEF_W-1:0] a, b, c;
		case (style)
			COEFS_PHYSICAL: begin
				a = $urandom_range(0, 32'h0800_0000);
				b = $urandom_range(0, 32'h0800_0000);
				c = COEF_W'((64'd1 << 56) / ((64'd1 << 28) + 64'd4 * b));
			end
			COEFS_EXTREME: begin
				a = $urandom_range(0, 1) ? COEF_MAX : '0;
				b = $urandom_range(0, 1) ? COEF_MAX : '0;
				c = $urandom_range(0, 1) ? COEF_MAX : '0;
			end
			default: begin
				a = $urandom;
				b = $urandom;
				c = $urandom;
			end
		endcase
		load_coefs(a, b, c, stray);
	endtask

	initial begin
		coef_style_t style;
		bit          steady;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: active cells pass through unchanged
		send_cell(fill_cell(VAL_MIN, 1'b1));
		send_cell(fill_cell(VAL_MAX, 1'b1));
		send_cell(fill_cell('0, 1'b1));
		send_cell(make_cell(VAL_ONE, VAL_MAX, VAL_MIN, 1, -1, 2, -2, 3, -3, VAL_MAX, VAL_MIN,
			1'b1));
		send_cell(fill_cell(VAL_MAX, 1'b0));

		// Typical coefficients: extremes, strong advection and diffusion
		drain_cells();
		load_coefs(ADVECT_TYPICAL, DIFFUSE_TYPICAL, SCALE_TYPICAL, 1'b0);
		send_cell(fill_cell(VAL_MIN, 1'b1));
		send_cell(fill_cell(VAL_MAX, 1'b1));
		send_cell(fill_cell(-1, 1'b1));
		send_cell(fill_cell('0, 1'b1));
		send_cell(make_cell('0, VAL_MAX, VAL_MIN, '0, '0, VAL_MAX, VAL_MIN, '0, '0,
			VAL_MAX, '0, 1'b1));
		send_cell(make_cell('0, '0, '0, VAL_MAX, VAL_MIN, '0, '0, VAL_MAX, VAL_MIN,
			'0, VAL_MIN, 1'b1));
		send_cell(make_cell(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
			VAL_MAX, VAL_MAX, '0, '0, 1'b1));
		send_cell(make_cell(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
			VAL_MIN, VAL_MIN, '0, '0, 1'b1));
		send_cell(make_cell(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
			VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 1'b0));
		send_cell(make_cell(VAL_ONE, 1, 0, 0, 0, 0, 0, 0, 0, VAL_ONE, -VAL_ONE, 1'b1));

		// Largest coefficients: results clamp both ways; the spare index is ignored
		drain_cells();
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
		send_cell(fill_cell(VAL_MAX, 1'b1));
		send_cell(fill_cell(VAL_MIN, 1'b1));
		send_cell(make_cell('0, VAL_MAX, VAL_MIN, '0, '0, VAL_MAX, VAL_MIN, '0, '0,
			VAL_MAX, VAL_MAX, 1'b1));
		send_cell(make_cell('0, VAL_MAX, VAL_MIN, '0, '0, VAL_MAX, VAL_MIN, '0, '0,
			VAL_MIN, VAL_MIN, 1'b1));
		send_cell(make_cell(VAL_ONE, '0, '0, '0, '0, '0, '0, '0, '0, 1, -1, 1'b1));
		send_cell(fill_cell(VAL_MAX, 1'b0));

		// Zero coefficients: active cells go to zero
		drain_cells();
		load_coefs('0, '0, '0, 1'b0);
		send_cell(fill_cell(VAL_MAX, 1'b1));
		send_cell(fill_cell(VAL_MIN, 1'b0));

		// Random cells under a new coefficient set per phase
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			style  = coef_style_t'(p % 3);
			steady = $urandom_range(0, 3) == 0;
			drain_cells();
			load_random_coefs(style, p % 2 == 1);
			for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
				send_cell(random_cell());
				pause_requests(gap_len(steady));
			end
		end

		drain_cells();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
sv/adcu_pkg.sv
sv/adcu_mulsh.sv
sv/advection_diffusion_cell_update_top.sv
dv/adcu_cell_checker.sv
dv/tb_advection_diffusion_cell_update_top.sv
